### src/hill_block_cipher_assert.svh
// ----------------------------------------------------------------------------
// Hill block cipher assertion macros
// Shared shorthand for the concurrent checks of the cipher block.
// ----------------------------------------------------------------------------
`ifndef HILL_BLOCK_CIPHER_ASSERT_SVH
`define HILL_BLOCK_CIPHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define HBC_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/hbc_pkg.sv
// ----------------------------------------------------------------------------
// Hill block cipher package
// Widths, register indexes and the controller-to-datapath command type.
// ----------------------------------------------------------------------------
package hbc_pkg;

  // Symbol and block geometry
  localparam int SYM_W     = 8;
  localparam int KEY_W     = 8;
  localparam int MAX_BLOCK = 4;
  localparam int IDX_W     = 2;
  localparam int N_W       = 3;
  localparam int MOD_W     = 9;

  // Accumulator covers four products of two 8-bit values
  localparam int SUM_W     = 18;
  localparam int MOD_BITS  = 3;
  localparam int MOD_STEPS = SUM_W / MOD_BITS;
  localparam int STEP_W    = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_ZERO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_ONE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_TWO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_THREE = 3'd5;

  // Register limits and reset values
  localparam logic [N_W-1:0]   BLOCK_MIN     = 3'd2;
  localparam logic [N_W-1:0]   BLOCK_MAX     = 3'd4;
  localparam logic [MOD_W-1:0] ALPHABET_MIN  = 9'd2;
  localparam logic [MOD_W-1:0] ALPHABET_MAX  = 9'd256;

  // Key matrix: row, then column, then 8-bit entry
  typedef logic [MAX_BLOCK-1:0][MAX_BLOCK-1:0][KEY_W-1:0] key_t;

  // Effective configuration seen by the controller and datapath
  typedef struct packed {
    logic [N_W-1:0]   block_n;
    logic [MOD_W-1:0] modulus;
    key_t             key;
  } cfg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             buf_wr;
    logic [IDX_W-1:0] wr_idx;
    logic             acc_clr;
    logic             acc_en;
    logic [IDX_W-1:0] mac_idx;
    logic [IDX_W-1:0] col;
    logic             mod_en;
    logic             out_load;
    logic             out_last;
  } cmd_t;

endpackage

### src/hbc_in_if.sv
// ----------------------------------------------------------------------------
// Hill block cipher plain symbol channel
// Valid/ready channel that carries one plain symbol per request.
// ----------------------------------------------------------------------------
interface hbc_in_if;
  logic                     valid;
  logic                     ready;
  logic [hbc_pkg::SYM_W-1:0] plain_symbol;

  modport source (output valid, output plain_symbol, input ready);
  modport sink (input valid, input plain_symbol, output ready);
endinterface

### src/hbc_out_if.sv
// ----------------------------------------------------------------------------
// Hill block cipher cipher symbol channel
// Valid/ready channel that carries one cipher symbol per request.
// ----------------------------------------------------------------------------
interface hbc_out_if;
  logic                       valid;
  logic                       ready;
  logic [hbc_pkg::SYM_W-1:0]  cipher_symbol;
  logic [hbc_pkg::IDX_W-1:0]  symbol_position;
  logic                       block_last;

  modport source (output valid, output cipher_symbol, output symbol_position,
                  output block_last, input ready);
  modport sink (input valid, input cipher_symbol, input symbol_position,
                input block_last, output ready);
endinterface

### src/hill_block_cipher.sv
// ----------------------------------------------------------------------------
// Hill block cipher
// Collects plain symbols into blocks and emits key-matrix products mod size.
// ----------------------------------------------------------------------------
// Usage:
//   plain_in carries one plain symbol per request. Symbols are collected
//   until block_size of them are held; the request that completes a block
//   starts the computation of block_size cipher symbols on cipher_out, in
//   position order, with block_last set on the final one.
//   Each cipher symbol is worked in turn: one shared 8x8 multiplier
//   accumulates one row per cycle, a remainder unit then reduces the 18-bit
//   sum three bits per cycle, and the result is loaded into the output
//   register. plain_in is not ready while a block is being worked.
//   Symbols that do not complete a block are taken one per cycle.
//   The output register lets the next plain symbol be taken while the last
//   cipher symbol of a block still waits. When cipher_out stalls, the block
//   holds the finished symbol and pauses before loading the next one.
//   Reset clears the fill count and the sequencer and restores block_size 2,
//   alphabet_size 256 and zero key rows. Write configuration only when idle.
// ----------------------------------------------------------------------------
module hill_block_cipher (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hbc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hbc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  hbc_in_if.sink                          plain_in,
  hbc_out_if.source                       cipher_out
);

  hbc_pkg::cfg_t cfg;
  hbc_pkg::cmd_t cmd;

  // Configuration registers
  hbc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Sequencer
  hbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .block_n_i   (cfg.block_n),
    .in_valid_i  (plain_in.valid),
    .in_ready_o  (plain_in.ready),
    .out_valid_o (cipher_out.valid),
    .out_ready_i (cipher_out.ready),
    .cmd_o       (cmd)
  );

  // Arithmetic and storage
  hbc_datapath u_datapath (
    .clk_i             (clk_i),
    .cmd_i             (cmd),
    .cfg_i             (cfg),
    .symbol_i          (plain_in.plain_symbol),
    .cipher_symbol_o   (cipher_out.cipher_symbol),
    .symbol_position_o (cipher_out.symbol_position),
    .block_last_o      (cipher_out.block_last)
  );

endmodule

### src/hbc_cfg.sv
// ----------------------------------------------------------------------------
// Hill block cipher configuration registers
// Holds block size, alphabet size and key rows; clamps sizes to range.
// ----------------------------------------------------------------------------
module hbc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hbc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hbc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output hbc_pkg::cfg_t                   cfg_o
);

  logic [hbc_pkg::N_W-1:0]   block_size_q;
  logic [hbc_pkg::MOD_W-1:0] alphabet_size_q;
  hbc_pkg::key_t             key_q;

  // Write registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q    <= hbc_pkg::BLOCK_MIN;
      alphabet_size_q <= hbc_pkg::ALPHABET_MAX;
      key_q           <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hbc_pkg::CFG_BLOCK_SIZE:    block_size_q    <= cfg_wdata_i[hbc_pkg::N_W-1:0];
        hbc_pkg::CFG_ALPHABET_SIZE: alphabet_size_q <= cfg_wdata_i[hbc_pkg::MOD_W-1:0];
        hbc_pkg::CFG_KEY_ROW_ZERO:  key_q[0]        <= cfg_wdata_i;
        hbc_pkg::CFG_KEY_ROW_ONE:   key_q[1]        <= cfg_wdata_i;
        hbc_pkg::CFG_KEY_ROW_TWO:   key_q[2]        <= cfg_wdata_i;
        hbc_pkg::CFG_KEY_ROW_THREE: key_q[3]        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp sizes to their legal ranges
  always_comb begin
    cfg_o.key = key_q;
    if (block_size_q < hbc_pkg::BLOCK_MIN) begin
      cfg_o.block_n = hbc_pkg::BLOCK_MIN;
    end else if (block_size_q > hbc_pkg::BLOCK_MAX) begin
      cfg_o.block_n = hbc_pkg::BLOCK_MAX;
    end else begin
      cfg_o.block_n = block_size_q;
    end
    if (alphabet_size_q < hbc_pkg::ALPHABET_MIN) begin
      cfg_o.modulus = hbc_pkg::ALPHABET_MIN;
    end else if (alphabet_size_q > hbc_pkg::ALPHABET_MAX) begin
      cfg_o.modulus = hbc_pkg::ALPHABET_MAX;
    end else begin
      cfg_o.modulus = alphabet_size_q;
    end
  end

endmodule

### src/hbc_datapath.sv
// ----------------------------------------------------------------------------
// Hill block cipher datapath
// Block buffer, multiply-accumulate, radix-8 remainder unit, output register.
// ----------------------------------------------------------------------------
module hbc_datapath (
  input  logic                        clk_i,
  input  hbc_pkg::cmd_t               cmd_i,
  input  hbc_pkg::cfg_t               cfg_i,
  input  logic [hbc_pkg::SYM_W-1:0]   symbol_i,
  output logic [hbc_pkg::SYM_W-1:0]   cipher_symbol_o,
  output logic [hbc_pkg::IDX_W-1:0]   symbol_position_o,
  output logic                        block_last_o
);

  logic [hbc_pkg::MAX_BLOCK-1:0][hbc_pkg::SYM_W-1:0] block_buffer_q;
  logic [hbc_pkg::SUM_W-1:0]   acc_q, acc_d;
  logic [hbc_pkg::SYM_W-1:0]   rem_q, rem_d;
  logic [2*hbc_pkg::SYM_W-1:0] product;
  logic [hbc_pkg::MOD_W-1:0]   rem_w;
  logic [hbc_pkg::SYM_W-1:0]   cipher_q;
  logic [hbc_pkg::IDX_W-1:0]   pos_q;
  logic                        last_q;

  // Store the incoming symbol at the fill position
  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_wr) begin
      block_buffer_q[cmd_i.wr_idx] <= symbol_i;
    end
  end

  // One product of the current column per cycle
  assign product = block_buffer_q[cmd_i.mac_idx] * cfg_i.key[cmd_i.mac_idx][cmd_i.col];

  // Accumulate, then shift the sum through the remainder unit
  always_comb begin
    acc_d = acc_q;
    rem_d = rem_q;
    rem_w = {1'b0, rem_q};
    if (cmd_i.acc_clr) begin
      acc_d = '0;
      rem_d = '0;
    end else if (cmd_i.acc_en) begin
      acc_d = acc_q + hbc_pkg::SUM_W'(product);
    end else if (cmd_i.mod_en) begin
      for (int b = 0; b < hbc_pkg::MOD_BITS; b++) begin
        rem_w = {rem_w[hbc_pkg::MOD_W-2:0], acc_q[hbc_pkg::SUM_W-1-b]};
        if (rem_w >= cfg_i.modulus) begin
          rem_w = rem_w - cfg_i.modulus;
        end
      end
      rem_d = rem_w[hbc_pkg::SYM_W-1:0];
      acc_d = acc_q << hbc_pkg::MOD_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      cipher_q <= rem_q;
      pos_q    <= cmd_i.col;
      last_q   <= cmd_i.out_last;
    end
  end

  assign cipher_symbol_o   = cipher_q;
  assign symbol_position_o = pos_q;
  assign block_last_o      = last_q;

endmodule

### src/hbc_ctrl.sv
// ----------------------------------------------------------------------------
// Hill block cipher controller
// Sequences block fill, per-column accumulation, reduction and output.
// ----------------------------------------------------------------------------
`include "hill_block_cipher_assert.svh"

module hbc_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [hbc_pkg::N_W-1:0]   block_n_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output hbc_pkg::cmd_t             cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [hbc_pkg::IDX_W-1:0]   fill_q, fill_d;
  logic [hbc_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic [hbc_pkg::IDX_W-1:0]   col_q, col_d;
  logic [hbc_pkg::STEP_W-1:0]  step_q, step_d;
  logic                        out_valid_q, out_valid_d;
  logic [hbc_pkg::N_W-1:0]     n_last;
  logic                        in_accept;
  logic                        block_done;
  logic                        idx_last;
  logic                        col_last;
  logic                        out_free;

  assign n_last     = block_n_i - hbc_pkg::N_W'(1);
  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign block_done = ({1'b0, fill_q} + hbc_pkg::N_W'(1)) >= block_n_i;
  assign idx_last   = {1'b0, idx_q} == n_last;
  assign col_last   = {1'b0, col_q} == n_last;
  assign out_free   = !out_valid_q || out_ready_i;

  // Next state and datapath commands
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    col_d       = col_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.wr_idx  = fill_q;
    cmd_o.mac_idx = idx_q;
    cmd_o.col     = col_q;
    cmd_o.out_last = col_last;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_o.buf_wr = 1'b1;
          if (block_done) begin
            fill_d        = '0;
            col_d         = '0;
            idx_d         = '0;
            cmd_o.acc_clr = 1'b1;
            state_d       = ST_MAC;
          end else begin
            fill_d = fill_q + hbc_pkg::IDX_W'(1);
          end
        end
      end
      ST_MAC: begin
        cmd_o.acc_en = 1'b1;
        if (idx_last) begin
          step_d  = '0;
          state_d = ST_MOD;
        end else begin
          idx_d = idx_q + hbc_pkg::IDX_W'(1);
        end
      end
      ST_MOD: begin
        cmd_o.mod_en = 1'b1;
        if (step_q == hbc_pkg::STEP_W'(hbc_pkg::MOD_STEPS - 1)) begin
          state_d = ST_EMIT;
        end else begin
          step_d = step_q + hbc_pkg::STEP_W'(1);
        end
      end
      ST_EMIT: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          if (col_last) begin
            state_d = ST_IDLE;
          end else begin
            col_d         = col_q + hbc_pkg::IDX_W'(1);
            idx_d         = '0;
            cmd_o.acc_clr = 1'b1;
            state_d       = ST_MAC;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      col_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      col_q       <= col_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

  // Checks
  `HBC_ASSERT_NEXT(a_last_returns_idle, clk_i, rst_ni, (state_q == ST_EMIT) && out_free && col_last, state_q == ST_IDLE, "last symbol of a block did not return to idle")
  `HBC_ASSERT_NEXT(a_mac_starts_at_zero, clk_i, rst_ni, (state_q != ST_MAC) && (state_d == ST_MAC), idx_q == '0, "accumulation did not start at row zero")
  `HBC_ASSERT_IMPLIES(a_valid_from_emit, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_EMIT, "output valid rose outside emit")
  `HBC_ASSERT_IMPLIES(a_step_in_range, clk_i, rst_ni, state_q == ST_MOD, step_q < hbc_pkg::STEP_W'(hbc_pkg::MOD_STEPS), "reduction step counter out of range")

endmodule

### tb/tb_hill_block_cipher.sv
// ----------------------------------------------------------------------------
// Hill block cipher testbench
// Drives plain symbols over several key and size settings and under varying
// source idle and sink stall rates, predicts every cipher symbol with a
// scoreboard that mirrors the registers and the block buffer, and compares
// each cipher request field by field in order.
// ----------------------------------------------------------------------------
module tb_hill_block_cipher;

  // Run bounds: settle covers a full block of four plus its accept cycles
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_PRINTS    = 20;

  // Register indexes past the end of the map; writes there must be dropped
  localparam logic [hbc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [hbc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic [hbc_pkg::SYM_W-1:0] symbol;
    logic [hbc_pkg::IDX_W-1:0] position;
    logic                      last;
  } cipher_req_t;

  // Mirror of the cipher state plus the queue of cipher symbols still owed
  class cipher_scoreboard;
    bit [hbc_pkg::N_W-1:0]        block_reg;
    bit [hbc_pkg::MOD_W-1:0]      alphabet_reg;
    bit [hbc_pkg::CFG_DATA_W-1:0] key_row[hbc_pkg::MAX_BLOCK];
    bit [hbc_pkg::SYM_W-1:0]      held[hbc_pkg::MAX_BLOCK];
    bit [hbc_pkg::IDX_W-1:0]      held_cnt;
    cipher_req_t                  owed_cipher[$];
    int unsigned                  mismatches;
    int unsigned                  checked;

    function new();
      block_reg    = hbc_pkg::BLOCK_MIN;
      alphabet_reg = hbc_pkg::ALPHABET_MAX;
      foreach (key_row[r]) key_row[r] = '0;
      held_cnt     = '0;
      mismatches   = 0;
      checked      = 0;
    endfunction

    function void write_reg(logic [hbc_pkg::CFG_IDX_W-1:0] idx,
                            logic [hbc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        hbc_pkg::CFG_BLOCK_SIZE:    block_reg    = data[hbc_pkg::N_W-1:0];
        hbc_pkg::CFG_ALPHABET_SIZE: alphabet_reg = data[hbc_pkg::MOD_W-1:0];
        hbc_pkg::CFG_KEY_ROW_ZERO:  key_row[0]   = data;
        hbc_pkg::CFG_KEY_ROW_ONE:   key_row[1]   = data;
        hbc_pkg::CFG_KEY_ROW_TWO:   key_row[2]   = data;
        hbc_pkg::CFG_KEY_ROW_THREE: key_row[3]   = data;
        default: ;
      endcase
    endfunction

    // Store one plain symbol; on a complete block, queue its cipher symbols
    function void note_symbol(logic [hbc_pkg::SYM_W-1:0] sym);
      int unsigned n;
      int unsigned m;
      int unsigned pos;
      int unsigned sum;
      cipher_req_t req;
      n = block_reg;
      if (n < hbc_pkg::BLOCK_MIN) n = hbc_pkg::BLOCK_MIN;
      if (n > hbc_pkg::BLOCK_MAX) n = hbc_pkg::BLOCK_MAX;
      m = alphabet_reg;
      if (m < hbc_pkg::ALPHABET_MIN) m = hbc_pkg::ALPHABET_MIN;
      if (m > hbc_pkg::ALPHABET_MAX) m = hbc_pkg::ALPHABET_MAX;
      pos = held_cnt;
      held[pos] = sym;
      if (pos + 1 < n) begin
        held_cnt = hbc_pkg::IDX_W'(pos + 1);
        return;
      end
      // Block complete (possibly early after the size was lowered)
      for (int k = 0; k < n; k++) begin
        sum = 0;
        for (int i = 0; i < n; i++)
          sum += int'(held[i]) * int'(key_row[i][8*k +: 8]);
        req.symbol   = hbc_pkg::SYM_W'(sum % m);
        req.position = hbc_pkg::IDX_W'(k);
        req.last     = (k == n - 1);
        owed_cipher.insert(owed_cipher.size(), req);
      end
      held_cnt = '0;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("tb_hill_block_cipher: mismatch: %s", what);
    endtask

    task check_cipher(cipher_req_t got);
      cipher_req_t want;
      if (owed_cipher.size() == 0) begin
        report_mismatch($sformatf("unexpected cipher request sym=%0d pos=%0d last=%0d",
                                  got.symbol, got.position, got.last));
        return;
      end
      want = owed_cipher.pop_front();
      checked++;
      if (got.symbol !== want.symbol)
        report_mismatch($sformatf("cipher_symbol %0d, expected %0d (pos %0d)",
                                  got.symbol, want.symbol, want.position));
      if (got.position !== want.position)
        report_mismatch($sformatf("symbol_position %0d, expected %0d",
                                  got.position, want.position));
      if (got.last !== want.last)
        report_mismatch($sformatf("block_last %0d, expected %0d (pos %0d)",
                                  got.last, want.last, want.position));
    endtask
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [hbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [hbc_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  hbc_in_if  plain_if ();
  hbc_out_if cipher_if ();

  cipher_scoreboard sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned symbols_sent   = 0;
  int unsigned reg_writes     = 0;
  int unsigned cycle_count    = 0;

  hill_block_cipher i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .plain_in    (plain_if),
    .cipher_out  (cipher_if)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: end the run if it never drains
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_hill_block_cipher: timeout after %0d cycles", cycle_count);
    $display("tb_hill_block_cipher: FAIL");
    $finish;
  end

  // Cipher sink: check each accepted request, stall at random
  initial begin : cipher_sink
    cipher_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && cipher_if.valid && cipher_if.ready)
        sb.check_cipher('{cipher_if.cipher_symbol, cipher_if.symbol_position,
                          cipher_if.block_last});
      cipher_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one plain symbol, idling first at random; leave valid high on return
  task automatic send_symbol(input logic [hbc_pkg::SYM_W-1:0] sym);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      plain_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    plain_if.valid        <= 1'b1;
    plain_if.plain_symbol <= sym;
    do @(posedge clk_i); while (!plain_if.ready);
    sb.note_symbol(sym);
    symbols_sent++;
  endtask

  // Drop valid, wait for every owed cipher symbol, then let the block settle
  task automatic wait_idle();
    plain_if.valid <= 1'b0;
    while (sb.owed_cipher.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; the caller drops the enable when done
  task automatic write_reg(input logic [hbc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hbc_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    reg_writes++;
  endtask

  task automatic apply_config(input logic [hbc_pkg::CFG_DATA_W-1:0] blk, alpha,
                              input logic [hbc_pkg::CFG_DATA_W-1:0] k0, k1, k2, k3);
    write_reg(hbc_pkg::CFG_BLOCK_SIZE, blk);
    write_reg(hbc_pkg::CFG_ALPHABET_SIZE, alpha);
    write_reg(hbc_pkg::CFG_KEY_ROW_ZERO, k0);
    write_reg(hbc_pkg::CFG_KEY_ROW_ONE, k1);
    write_reg(hbc_pkg::CFG_KEY_ROW_TWO, k2);
    write_reg(hbc_pkg::CFG_KEY_ROW_THREE, k3);
    cfg_we_i <= 1'b0;
  endtask

  // Pick a random setting, mostly legal sizes, with garbage in unused bits
  task automatic load_random_config();
    logic [hbc_pkg::N_W-1:0]        blk;
    logic [hbc_pkg::MOD_W-1:0]      alpha;
    logic [hbc_pkg::CFG_DATA_W-1:0] rows[hbc_pkg::MAX_BLOCK];
    blk = ($urandom_range(4) == 0) ?
          hbc_pkg::N_W'($urandom_range(7)) :
          hbc_pkg::N_W'($urandom_range(hbc_pkg::BLOCK_MAX, hbc_pkg::BLOCK_MIN));
    case ($urandom_range(5))
      0:       alpha = hbc_pkg::ALPHABET_MIN;
      1:       alpha = hbc_pkg::ALPHABET_MAX;
      2:       alpha = hbc_pkg::MOD_W'($urandom_range(511));
      default: alpha = hbc_pkg::MOD_W'($urandom_range(hbc_pkg::ALPHABET_MAX,
                                                      hbc_pkg::ALPHABET_MIN));
    endcase
    foreach (rows[r]) rows[r] = ($urandom_range(7) == 0) ? '1 : $urandom();
    apply_config(($urandom() & ~32'h7) | blk, ($urandom() & ~32'h1ff) | alpha,
                 rows[0], rows[1], rows[2], rows[3]);
  endtask

  // Stimulus
  initial begin : stimulus
    int unsigned idle_plan[4];
    int unsigned stall_plan[4];
    idle_plan  = '{0, 45, 0, 28};
    stall_plan = '{0, 0, 45, 28};

    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = '0;
    cfg_wdata_i           = '0;
    plain_if.valid        = 1'b0;
    plain_if.plain_symbol = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: size two, full alphabet, zero key
    send_symbol(8'hff);
    send_symbol(8'h00);
    wait_idle();

    // Largest sums: size four, all-ones key and symbols
    apply_config(4, 256, '1, '1, '1, '1);
    repeat (4) send_symbol(8'hff);
    wait_idle();

    // Sizes below range clamp up to the minimum
    apply_config(1, 1, 32'h01ff_80c3, 32'h7f02_33aa, 32'h5555_aaaa, 32'h0f0f_f0f0);
    send_symbol(8'h80);
    send_symbol(8'h7f);
    wait_idle();

    // Sizes above range clamp down to the maximum, then a zero alphabet clamps up
    apply_config(7, 511, 32'hdead_beef, 32'h1234_5678, 32'h8765_4321, 32'hfeed_c0de);
    send_symbol(8'h01);
    send_symbol(8'hfe);
    send_symbol(8'h55);
    send_symbol(8'haa);
    wait_idle();
    apply_config(5, 0, 32'hc001_d00d, 32'h0bad_f00d, 32'h1357_9bdf, 32'h2468_ace0);
    repeat (4) send_symbol(8'($urandom_range(255)));
    wait_idle();

    // Three-symbol blocks, alphabet just past the top
    apply_config(3, 257, 32'h0003_0201, 32'h0006_0504, 32'h0009_0807, 32'h0);
    send_symbol(8'd10);
    send_symbol(8'd20);
    send_symbol(8'd30);
    wait_idle();

    // Shrink the block with three symbols held: next symbol completes it at once
    apply_config(4, 97, 32'h4433_2211, 32'h8877_6655, 32'hccbb_aa99, 32'h00ff_eedd);
    send_symbol(8'd200);
    send_symbol(8'd13);
    send_symbol(8'd77);
    wait_idle();
    write_reg(CFG_UNMAPPED_LO, 32'hffff_ffff);
    write_reg(CFG_UNMAPPED_HI, 32'h0000_0003);
    write_reg(hbc_pkg::CFG_BLOCK_SIZE, 2);
    cfg_we_i <= 1'b0;
    send_symbol(8'd250);
    wait_idle();

    // Random blocks across idle/stall mixes and settings
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_plan[ph];
      recv_stall_pct = stall_plan[ph];
      for (int seg = 0; seg < 4; seg++) begin
        wait_idle();
        load_random_config();
        repeat (26) send_symbol(hbc_pkg::SYM_W'($urandom_range(255)));
      end
    end

    // Drain
    recv_stall_pct = 0;
    wait_idle();
    if (sb.owed_cipher.size() != 0)
      sb.report_mismatch($sformatf("%0d cipher symbols never arrived",
                                   sb.owed_cipher.size()));

    $display("tb_hill_block_cipher: %0d plain requests, %0d cipher requests checked",
             symbols_sent, sb.checked);
    $display("tb_hill_block_cipher: %0d register writes, clamped and legal sizes",
             reg_writes);
    $display("tb_hill_block_cipher: %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb_hill_block_cipher: PASS");
    end else begin
      $display("tb_hill_block_cipher: FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/hbc_pkg.sv
src/hbc_in_if.sv
src/hbc_out_if.sv
src/hbc_cfg.sv
src/hbc_datapath.sv
src/hbc_ctrl.sv
src/hill_block_cipher.sv
tb/tb_hill_block_cipher.sv
